/* rtl/core/rgblt_pkg.sv */
`default_nettype none

package rgblt_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int CHAR_ADVANCE_DEF  = 9;
  localparam int MAX_STRING_DEF    = 64;

  localparam int GLYPH_COUNT = 10;
  localparam int GIDX_W      = $clog2(GLYPH_COUNT);

  typedef enum logic [1:0] {
    ROT_UPRIGHT = 2'd0,
    ROT_CCW     = 2'd1,
    ROT_HALF    = 2'd2,
    ROT_CW      = 2'd3
  } rot_t;

  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h00},
    '{8'h3C, 8'h66, 8'h60, 8'h60, 8'h60, 8'h66, 8'h3C, 8'h00},
    '{8'h78, 8'h6C, 8'h66, 8'h66, 8'h66, 8'h6C, 8'h78, 8'h00},
    '{8'h66, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h00},
    '{8'h7E, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h00},
    '{8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h7E, 8'h00},
    '{8'h66, 8'h76, 8'h7E, 8'h7E, 8'h6E, 8'h66, 8'h66, 8'h00},
    '{8'h7C, 8'h66, 8'h66, 8'h7C, 8'h6C, 8'h66, 8'h66, 8'h00},
    '{8'h3C, 8'h66, 8'h60, 8'h3C, 8'h06, 8'h66, 8'h3C, 8'h00}
  };

  function automatic logic [GIDX_W-1:0] rom_index(input logic [7:0] code);
    logic [GIDX_W-1:0] idx;
    unique case (code)
      "A":     idx = GIDX_W'(1);
      "C":     idx = GIDX_W'(2);
      "D":     idx = GIDX_W'(3);
      "H":     idx = GIDX_W'(4);
      "I":     idx = GIDX_W'(5);
      "L":     idx = GIDX_W'(6);
      "N":     idx = GIDX_W'(7);
      "R":     idx = GIDX_W'(8);
      "S":     idx = GIDX_W'(9);
      default: idx = '0;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] glyph_row(input logic [GIDX_W-1:0] idx,
                                           input logic [2:0] row);
    logic [7:0] bits;
    if (idx > GIDX_W'(GLYPH_COUNT - 1)) begin
      bits = '0;
    end else begin
      bits = GLYPH_ROM[idx][row];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rgblt_pix.sv */
`default_nettype none

module rgblt_pix #(
  parameter int SCREEN_WIDTH  = rgblt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rgblt_pkg::SCREEN_HEIGHT_DEF,
  parameter int CORNER_W      = 14
) (
  input  wire logic [rgblt_pkg::GIDX_W-1:0] glyph,
  input  wire rgblt_pkg::rot_t              rot,
  input  wire logic [5:0]                   cell_idx,
  input  wire logic signed [CORNER_W-1:0]   gx,
  input  wire logic signed [CORNER_W-1:0]   gy,
  output logic                              vis,
  output logic [15:0]                       addr
);
  import rgblt_pkg::*;

  localparam int X_W  = CORNER_W + 1;
  localparam int XI_W = $clog2(SCREEN_WIDTH);
  localparam int YI_W = $clog2(SCREEN_HEIGHT);
  localparam int WC_W = $clog2(SCREEN_WIDTH + 1);

  logic [2:0]              row, col, px, py;
  logic [7:0]              bits;
  logic                    set;
  logic signed [X_W-1:0]   x, y;
  logic                    on_screen;
  logic [YI_W+WC_W-1:0]    prod;

  assign row  = cell_idx[5:3];
  assign col  = cell_idx[2:0];
  assign bits = glyph_row(glyph, row);
  assign set  = bits[3'd7 - col];

  always_comb begin
    unique case (rot)
      ROT_CCW:   begin px = row;        py = 3'd7 - col; end
      ROT_CW:    begin px = 3'd7 - row; py = col;        end
      ROT_HALF:  begin px = 3'd7 - col; py = 3'd7 - row; end
      default:   begin px = col;        py = row;        end
    endcase
  end

  assign x = X_W'(gx) + $signed(X_W'(px));
  assign y = X_W'(gy) + $signed(X_W'(py));

  assign on_screen = (x >= 0) && (y >= 0) &&
                     (x < $signed(X_W'(SCREEN_WIDTH))) &&
                     (y < $signed(X_W'(SCREEN_HEIGHT)));
  assign vis = set && on_screen;

  assign prod = y[YI_W-1:0] * WC_W'(SCREEN_WIDTH);
  assign addr = 16'(prod) + 16'(x[XI_W-1:0]);

endmodule

`default_nettype wire

/* rtl/core/rotated_glyph_blitter.sv */
`default_nettype none

// channel | handshake           | payload per transfer
// in      | in_valid/in_ready   | one character: code, position, length, origin, rotation, color
// out     | out_valid/out_ready | one pixel write: address, color, last_pixel
// A character holds the block from one accept to the next: a scan of all 64 cells
// through the shared placement/address unit, the flush state, then idle.
// A visible pixel that waits on out_ready stalls the scan.
// One visible pixel is held back so the final one can carry last_pixel.
// in_ready is high only between characters. rst_n is synchronous, active low.

module rotated_glyph_blitter #(
  parameter int SCREEN_WIDTH  = rgblt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rgblt_pkg::SCREEN_HEIGHT_DEF,
  parameter int CHAR_ADVANCE  = rgblt_pkg::CHAR_ADVANCE_DEF,
  parameter int MAX_STRING    = rgblt_pkg::MAX_STRING_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [5:0]         in_char_position,
  input  wire logic [6:0]         in_string_length,
  input  wire logic signed [10:0] in_origin_x,
  input  wire logic signed [10:0] in_origin_y,
  input  wire logic [1:0]         in_rotation,
  input  wire logic [7:0]         in_ink_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_pixel_address,
  output logic [7:0]              out_pixel_color,
  output logic                    out_last_pixel
);
  import rgblt_pkg::*;

  localparam int SLOT_W   = $clog2(MAX_STRING + 64) + 1;
  localparam int ADV_W    = $clog2(CHAR_ADVANCE + 1) + 1;
  localparam int PROD_W   = SLOT_W + ADV_W;
  localparam int CORNER_W = ((PROD_W > 11) ? PROD_W : 11) + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t                      state_r;
  logic [GIDX_W-1:0]           glyph_r;
  rot_t                        rot_r;
  logic signed [CORNER_W-1:0]  gx_r, gy_r;
  logic [7:0]                  color_r;
  logic [5:0]                  cnt_r;
  logic                        pend_vld_r;
  logic [15:0]                 pend_addr_r;
  logic                        out_valid_r;
  logic [15:0]                 out_addr_r;
  logic [7:0]                  out_color_r;
  logic                        out_last_r;

  rot_t                        in_rot;
  logic signed [SLOT_W-1:0]    len_s, len_c, pos_s, slot;
  logic signed [PROD_W-1:0]    adv_off;
  logic signed [CORNER_W-1:0]  off, ox_s, oy_s;
  logic                        vis;
  logic [15:0]                 addr;
  logic                        out_free, step;
  logic                        push_mid, push_last;

  assign in_rot  = rot_t'(in_rotation);
  assign len_s   = SLOT_W'(in_string_length);
  assign len_c   = (len_s > SLOT_W'(MAX_STRING)) ? SLOT_W'(MAX_STRING) : len_s;
  assign pos_s   = SLOT_W'(in_char_position);
  assign slot    = (in_rot == ROT_HALF) ? (len_c - pos_s - SLOT_W'(1)) : pos_s;
  assign adv_off = slot * $signed(ADV_W'(CHAR_ADVANCE));
  assign off     = CORNER_W'(adv_off);
  assign ox_s    = CORNER_W'(in_origin_x);
  assign oy_s    = CORNER_W'(in_origin_y);

  rgblt_pix #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CORNER_W      (CORNER_W)
  ) u_pix (
    .glyph    (glyph_r),
    .rot      (rot_r),
    .cell_idx (cnt_r),
    .gx       (gx_r),
    .gy       (gy_r),
    .vis      (vis),
    .addr     (addr)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign step      = (state_r == ST_SCAN) && !(vis && pend_vld_r && !out_free);
  assign push_mid  = step && vis && pend_vld_r;
  assign push_last = (state_r == ST_FLUSH) && pend_vld_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push_mid || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            glyph_r <= rom_index(in_char_code);
            rot_r   <= in_rot;
            color_r <= in_ink_color;
            cnt_r   <= '0;
            if (in_rot == ROT_UPRIGHT || in_rot == ROT_HALF) begin
              gx_r <= ox_s + off;
              gy_r <= oy_s;
            end else begin
              gx_r <= ox_s;
              gy_r <= oy_s + off;
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            cnt_r <= cnt_r + 6'd1;
            if (vis) begin
              if (pend_vld_r) begin
                out_addr_r  <= pend_addr_r;
                out_color_r <= color_r;
                out_last_r  <= 1'b0;
              end
              pend_addr_r <= addr;
              pend_vld_r  <= 1'b1;
            end
            if (cnt_r == 6'd63) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_addr_r  <= pend_addr_r;
            out_color_r <= color_r;
            out_last_r  <= 1'b1;
            pend_vld_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_pixel    = out_last_r;

`ifndef NO_ASSERTIONS
  a_no_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_vld_r)
    else $error("held pixel left over between characters");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == 6'd0))
    else $error("cell counter not back at zero when idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(out_addr_r) && $stable(out_last_r)))
    else $error("pixel write changed while stalled");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && pend_vld_r && out_free) |=> (out_valid_r && out_last_r))
    else $error("flush did not deliver the final pixel");
`endif

endmodule

`default_nettype wire
